[sv/wrat_pkg.sv]
// Package for the weekly relay alarm table: request codes, time constants
// and the structs passed between the top level, the slot cells and the time unit.
// No dependencies.
`timescale 1ns / 1ps

package wrat_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  // Response kinds.
  localparam logic RESP_ACK = 1'b0;
  localparam logic RESP_CMD = 1'b1;

  // Weekday code stored for "any day", and the last real weekday code.
  localparam logic [3:0] WILD_DAY = 4'd8;
  localparam logic [3:0] LAST_DAY = 4'd6;

  // Slot count default and the cap on relay commands per tick.
  localparam int unsigned DEF_SLOTS   = 16;
  localparam int unsigned MAX_RESULTS = 16;

  // Minute value meaning "no minute checked yet".
  localparam logic [6:0] NO_MINUTE = 7'd127;

  // Seconds per day and per hour, and days per week.
  localparam logic [16:0] DIV_DAY  = 17'd86400;
  localparam logic [11:0] DIV_HOUR = 12'd3600;
  localparam logic [2:0]  DIV_WEEK = 3'd7;

  // Reciprocals for division by a constant: the quotient is (x * R) >> S for
  // every x of the width that reaches it, after the power-of-two factor of
  // the divisor has been shifted out of x.
  localparam logic [25:0] RCP_DAY  = 26'd50903317;  // (t >> 7) / 675, S = 35
  localparam logic [13:0] RCP_HOUR = 14'd9321;      // (s >> 4) / 225, S = 21
  localparam logic [10:0] RCP_MIN  = 11'd1093;      // (s >> 2) / 15, S = 14
  localparam logic [16:0] RCP_WEEK = 17'd74899;     // d / 7, S = 19

  // Day 0 of Unix time was a Thursday.
  localparam logic [15:0] EPOCH_WEEKDAY = 16'd4;

  // Slot write broadcast from the top level to every cell.
  typedef struct packed {
    logic       add;
    logic       remove;
    logic [7:0] slot_id;
    logic [7:0] relay;
    logic [3:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic       turn_on;
  } slot_wr_t;

  // Time of day broadcast to the cells; en marks a new minute to check.
  typedef struct packed {
    logic       en;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [2:0] day;
  } tod_t;

  // Relay command held in a cell's output stage.
  typedef struct packed {
    logic [7:0] relay;
    logic       turn_on;
    logic [4:0] slot_id;
  } cmd_t;

  // One stage of the command shift chain.
  typedef struct packed {
    logic pend;
    cmd_t cmd;
  } stage_t;

endpackage

[sv/wrat_time.sv]
// Time unit: splits Unix time into hour, minute and weekday with constant
// reciprocal multiplications spread over a five-stage pipeline.
// Depends on wrat_pkg.
`timescale 1ns / 1ps

module wrat_time (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [31:0]   time_i,
  output wrat_pkg::tod_t tod_o
);
  import wrat_pkg::*;

  logic [3:0]  vld_q;
  logic        done_q;
  logic [31:0] time_q;
  logic [15:0] days_q;
  logic [16:0] sod_q;
  logic [15:0] wday_q;
  logic [4:0]  hour_q;
  logic [12:0] weeks_q;
  logic [11:0] soh_q;
  logic [2:0]  day_q;
  logic [5:0]  minute_q;

  logic [50:0] day_prod;
  logic [32:0] day_secs;
  logic [32:0] sod_full;
  logic [25:0] hour_prod;
  logic [31:0] week_prod;
  logic [16:0] hour_secs;
  logic [16:0] soh_full;
  logic [15:0] week_days;
  logic [15:0] day_full;
  logic [19:0] min_prod;

  // Per-stage arithmetic: constant multiplies, each with at most one subtract after it.
  always_comb begin
    day_prod  = 51'(time_i[31:7]) * 51'(RCP_DAY);
    day_secs  = 33'(days_q) * 33'(DIV_DAY);
    sod_full  = {1'b0, time_q} - day_secs;
    hour_prod = 26'(sod_q[16:4]) * 26'(RCP_HOUR);
    week_prod = 32'(wday_q) * 32'(RCP_WEEK);
    hour_secs = 17'(hour_q) * 17'(DIV_HOUR);
    soh_full  = sod_q - hour_secs;
    week_days = 16'(weeks_q) * 16'(DIV_WEEK);
    day_full  = wday_q - week_days;
    min_prod  = 20'(soh_q[11:2]) * 20'(RCP_MIN);
  end

  // Stage valid marks; done pulses once the minute is ready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[2:0], start_i};
      done_q <= vld_q[3];
    end
  end

  // Datapath: days, second of day, hour and week count, then second of
  // hour and weekday, then minute of hour.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      time_q <= time_i;
      days_q <= day_prod[50:35];
    end
    if (vld_q[0]) begin
      sod_q  <= sod_full[16:0];
      wday_q <= days_q + EPOCH_WEEKDAY;
    end
    if (vld_q[1]) begin
      hour_q  <= hour_prod[25:21];
      weeks_q <= week_prod[31:19];
    end
    if (vld_q[2]) begin
      soh_q <= soh_full[11:0];
      day_q <= day_full[2:0];
    end
    if (vld_q[3]) begin
      minute_q <= min_prod[19:14];
    end
  end

  assign tod_o.en     = done_q;
  assign tod_o.hour   = hour_q;
  assign tod_o.minute = minute_q;
  assign tod_o.day    = day_q;

endmodule

[sv/wrat_cell.sv]
// One alarm slot cell: holds the slot's rule, active and fired marks, and
// one stage of the command chain that shifts toward cell 0.
// Depends on wrat_pkg.
`timescale 1ns / 1ps

module wrat_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wrat_pkg::slot_wr_t wr_i,
  input  wrat_pkg::tod_t    tod_i,
  input  logic              shift_i,
  input  wrat_pkg::stage_t  stage_i,
  input  logic              any_i,
  output wrat_pkg::stage_t  stage_o,
  output logic              any_o,
  output logic              active_o
);
  import wrat_pkg::*;

  localparam logic [7:0] SlotId = 8'(IDX + 1);

  logic       active_q;
  logic       fired_q;
  logic [7:0] relay_q;
  logic [3:0] day_q;
  logic [4:0] hour_q;
  logic [5:0] minute_q;
  logic       on_q;
  logic       pend_q;
  cmd_t       cmd_q;

  logic hit;
  logic time_match;
  logic day_match;
  logic fire;

  // Match of this slot against the broadcast request and time of day.
  always_comb begin
    hit        = (wr_i.slot_id == SlotId);
    time_match = (hour_q == tod_i.hour) && (minute_q == tod_i.minute);
    day_match  = (day_q == WILD_DAY) || (day_q == {1'b0, tod_i.day});
    fire       = active_q && !fired_q && time_match && day_match;
  end

  // Active and fired marks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      fired_q  <= 1'b0;
    end else if (wr_i.add && hit) begin
      active_q <= 1'b1;
      fired_q  <= 1'b0;
    end else if (wr_i.remove && hit) begin
      active_q <= 1'b0;
    end else if (tod_i.en && active_q) begin
      if (fire) begin
        fired_q <= 1'b1;
      end else if (!time_match) begin
        fired_q <= 1'b0;
      end
    end
  end

  // Rule storage, written by an add.
  always_ff @(posedge clk_i) begin
    if (wr_i.add && hit) begin
      relay_q  <= wr_i.relay;
      day_q    <= wr_i.day;
      hour_q   <= wr_i.hour;
      minute_q <= wr_i.minute;
      on_q     <= wr_i.turn_on;
    end
  end

  // Command stage: loaded on a time check, then shifted toward cell 0.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (tod_i.en) begin
      pend_q <= fire;
    end else if (shift_i) begin
      pend_q <= stage_i.pend;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tod_i.en) begin
      cmd_q.relay   <= relay_q;
      cmd_q.turn_on <= on_q;
      cmd_q.slot_id <= SlotId[4:0];
    end else if (shift_i) begin
      cmd_q <= stage_i.cmd;
    end
  end

  assign stage_o.pend = pend_q;
  assign stage_o.cmd  = cmd_q;
  assign any_o        = pend_q | any_i;
  assign active_o     = active_q;

endmodule

[sv/weekly_relay_alarm_table.sv]
// Top level of the weekly relay alarm table: request decode, control
// sequencer, the row of slot cells, the time unit and the output register.
// Depends on wrat_pkg, wrat_cell and wrat_time.
//
// Usage. One input channel carries requests: add a slot, remove a slot, or a
// time tick. The output channel carries an acknowledgement for each add or
// remove and one relay command per slot that fires on a tick, in slot order,
// with last on the final result. Both use valid and stall.
// Flow. An add or remove goes to the acknowledge state and is acknowledged
// in the output register once that register is free. A synced tick passes
// the five-stage time unit, checks all slots at once and then shifts the
// command chain one cell per cycle, unless an output stall holds the chain
// head. A tick with nothing due, a repeated minute, an unsynced tick or an
// unknown request code gives no result. One request is worked at a time.
// Reset clears every slot's active and fired marks and the last checked
// minute. A stall on the output holds the output register and, once the
// chain head waits on it, the whole scan.
`timescale 1ns / 1ps

module weekly_relay_alarm_table #(
  parameter int unsigned SLOTS = wrat_pkg::DEF_SLOTS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  slot_id_i,
  input  logic [7:0]  relay_index_i,
  input  logic [3:0]  weekday_code_i,
  input  logic [4:0]  alarm_hour_i,
  input  logic [5:0]  alarm_minute_i,
  input  logic        turn_on_i,
  input  logic [31:0] unix_time_i,
  input  logic        clock_synced_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        resp_kind_o,
  output logic        op_ok_o,
  output logic [7:0]  cmd_relay_o,
  output logic        cmd_on_o,
  output logic [4:0]  fired_slot_id_o,
  output logic        last_o
);
  import wrat_pkg::*;

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_RESULTS);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACK  = 3'd1;
  localparam logic [2:0] S_TIME = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;

  logic [2:0]       state_q, state_d;
  logic             ack_ok_q, ack_ok_d;
  logic [6:0]       last_min_q, last_min_d;
  logic [CNT_W-1:0] emit_cnt_q, emit_cnt_d;

  logic             out_vld_q;
  logic             kind_q;
  logic             ok_q;
  logic [7:0]       relay_q;
  logic             on_q;
  logic [4:0]       sid_q;
  logic             last_q;

  logic             in_acc;
  logic             id_ok;
  logic [7:0]       id_m1;
  logic [IDX_W-1:0] idx;
  logic             rem_ok;
  logic             out_free;
  logic             load_ack;
  logic             load_cmd;
  logic             cmd_last;
  logic             shift;
  logic             time_start;

  slot_wr_t         wr;
  tod_t             tm;
  tod_t             tod;
  stage_t           stg_w [SLOTS+1];
  logic             any_w [SLOTS+1];
  logic [SLOTS-1:0] active_w;

  // Request decode.
  always_comb begin
    in_acc = in_valid_i && !in_stall_o;
    id_ok  = (slot_id_i >= 8'd1) && (slot_id_i <= 8'(SLOTS));
    id_m1  = slot_id_i - 8'd1;
    idx    = id_m1[IDX_W-1:0];
    rem_ok = id_ok && active_w[idx];

    wr.add     = in_acc && (req_type_i == REQ_ADD) && id_ok;
    wr.remove  = in_acc && (req_type_i == REQ_REMOVE) && rem_ok;
    wr.slot_id = slot_id_i;
    wr.relay   = relay_index_i;
    wr.day     = (weekday_code_i > LAST_DAY) ? WILD_DAY : weekday_code_i;
    wr.hour    = alarm_hour_i;
    wr.minute  = alarm_minute_i;
    wr.turn_on = turn_on_i;

    time_start = in_acc && (req_type_i == REQ_TICK) && clock_synced_i;
  end

  // Time of day goes to the cells only when the minute has changed.
  always_comb begin
    tod    = tm;
    tod.en = (state_q == S_TIME) && tm.en && ({1'b0, tm.minute} != last_min_q);
  end

  // Output register handshake and chain control.
  always_comb begin
    out_free = !out_vld_q || !out_stall_i;
    load_ack = (state_q == S_ACK) && out_free;
    load_cmd = (state_q == S_SCAN) && stg_w[0].pend && out_free;
    cmd_last = (emit_cnt_q == CNT_W'(MAX_RESULTS - 1)) || !any_w[1];
    shift    = (state_q == S_SCAN) && (!stg_w[0].pend || out_free);
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    ack_ok_d   = ack_ok_q;
    last_min_d = last_min_q;
    emit_cnt_d = emit_cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (req_type_i)
            REQ_ADD: begin
              ack_ok_d = id_ok;
              state_d  = S_ACK;
            end
            REQ_REMOVE: begin
              ack_ok_d = rem_ok;
              state_d  = S_ACK;
            end
            REQ_TICK: begin
              if (clock_synced_i) begin
                state_d = S_TIME;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_ACK: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_TIME: begin
        if (tm.en) begin
          if (tod.en) begin
            last_min_d = {1'b0, tm.minute};
            emit_cnt_d = '0;
            state_d    = S_SCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        if (load_cmd) begin
          emit_cnt_d = emit_cnt_q + CNT_W'(1);
          if (cmd_last) begin
            state_d = S_IDLE;
          end
        end else if (!any_w[0]) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ack_ok_q   <= 1'b0;
      last_min_q <= NO_MINUTE;
      emit_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      ack_ok_q   <= ack_ok_d;
      last_min_q <= last_min_d;
      emit_cnt_q <= emit_cnt_d;
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_ack || load_cmd) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (load_ack) begin
      kind_q  <= RESP_ACK;
      ok_q    <= ack_ok_q;
      relay_q <= '0;
      on_q    <= 1'b0;
      sid_q   <= '0;
      last_q  <= 1'b1;
    end else if (load_cmd) begin
      kind_q  <= RESP_CMD;
      ok_q    <= 1'b0;
      relay_q <= stg_w[0].cmd.relay;
      on_q    <= stg_w[0].cmd.turn_on;
      sid_q   <= stg_w[0].cmd.slot_id;
      last_q  <= cmd_last;
    end
  end

  // Time unit.
  wrat_time u_time (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (time_start),
    .time_i  (unix_time_i),
    .tod_o   (tm)
  );

  // Row of slot cells; commands shift toward cell 0.
  assign stg_w[SLOTS] = '0;
  assign any_w[SLOTS] = 1'b0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    wrat_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .wr_i     (wr),
      .tod_i    (tod),
      .shift_i  (shift),
      .stage_i  (stg_w[g+1]),
      .any_i    (any_w[g+1]),
      .stage_o  (stg_w[g]),
      .any_o    (any_w[g]),
      .active_o (active_w[g])
    );
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_vld_q;
  assign resp_kind_o     = kind_q;
  assign op_ok_o         = ok_q;
  assign cmd_relay_o     = relay_q;
  assign cmd_on_o        = on_q;
  assign fired_slot_id_o = sid_q;
  assign last_o          = last_q;

endmodule

[sv/wrat_checker.sv]
// Port-level checks for the weekly relay alarm table, bound to its top level.
// Depends on wrat_pkg and weekly_relay_alarm_table.
`timescale 1ns / 1ps

module wrat_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  req_type_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        resp_kind_o,
  input logic        op_ok_o,
  input logic [7:0]  cmd_relay_o,
  input logic        cmd_on_o,
  input logic [4:0]  fired_slot_id_o,
  input logic        last_o
);
  import wrat_pkg::*;

  // A stalled result item stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // A stalled result item keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(resp_kind_o) && $stable(op_ok_o) && $stable(cmd_relay_o) &&
      $stable(cmd_on_o) && $stable(fired_slot_id_o) && $stable(last_o))
    else $error("result item changed while stalled");

  // An acknowledgement is the only result of its request and carries no command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (resp_kind_o == RESP_ACK) |->
      last_o && !cmd_on_o && (cmd_relay_o == 8'd0) && (fired_slot_id_o == 5'd0))
    else $error("malformed acknowledgement");

  // A relay command never reports op_ok.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (resp_kind_o == RESP_CMD) |-> !op_ok_o)
    else $error("relay command with op_ok set");

  // An accepted add holds off the next item while its acknowledgement is pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == REQ_ADD) |=> in_stall_o)
    else $error("item accepted while an acknowledgement is pending");

endmodule

bind weekly_relay_alarm_table wrat_checker u_wrat_checker (.*);

[sim/tb_weekly_relay_alarm_table.sv]
// Self-checking testbench for the weekly relay alarm table.
// Drives add, remove and tick items, predicts every result in step with the DUT and checks
// each one in order. Depends on wrat_pkg and weekly_relay_alarm_table.
`timescale 1ns / 1ps

module tb_weekly_relay_alarm_table;
  import wrat_pkg::*;

  localparam int unsigned SLOTS         = DEF_SLOTS;
  localparam logic [1:0]  REQ_UNUSED    = 2'd3;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          SETTLE_CYCLES = 200;
  localparam logic [31:0] BASE_TIME     = 32'd1641637200;

  // One input item as the sender sees it.
  typedef struct packed {
    logic [1:0]  req;
    logic [7:0]  slot_id;
    logic [7:0]  relay;
    logic [3:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic        turn_on;
    logic [31:0] unix_time;
    logic        synced;
  } alarm_req_t;

  // One result item, in port order.
  typedef struct packed {
    logic       kind;
    logic       ok;
    logic [7:0] relay;
    logic       turn_on;
    logic [4:0] slot_id;
    logic       is_last;
  } alarm_result_t;

  // Stored alarm rule of one slot.
  typedef struct packed {
    logic [7:0] relay;
    logic [3:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
    logic       turn_on;
  } slot_rule_t;

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i     = REQ_UNUSED;
  logic [7:0]  slot_id_i      = '0;
  logic [7:0]  relay_index_i  = '0;
  logic [3:0]  weekday_code_i = '0;
  logic [4:0]  alarm_hour_i   = '0;
  logic [5:0]  alarm_minute_i = '0;
  logic        turn_on_i      = 1'b0;
  logic [31:0] unix_time_i    = '0;
  logic        clock_synced_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic        resp_kind_o;
  logic        op_ok_o;
  logic [7:0]  cmd_relay_o;
  logic        cmd_on_o;
  logic [4:0]  fired_slot_id_o;
  logic        last_o;

  // Predicted table contents.
  bit          table_live  [SLOTS];
  bit          table_fired [SLOTS];
  slot_rule_t  table_rule  [SLOTS];
  logic [6:0]  minute_checked = NO_MINUTE;

  alarm_result_t expected_results[$];

  // Run control and statistics.
  logic        quiet          = 1'b0;
  int          hold_req_count = 0;
  int          hold_seen      = 0;
  int          hold_left      = 0;
  logic [31:0] wall_clock     = '0;
  int          items_accepted   = 0;
  int          results_checked  = 0;
  int          commands_checked = 0;
  int          fail_count       = 0;
  int          cycle_count      = 0;

  weekly_relay_alarm_table #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .slot_id_i      (slot_id_i),
    .relay_index_i  (relay_index_i),
    .weekday_code_i (weekday_code_i),
    .alarm_hour_i   (alarm_hour_i),
    .alarm_minute_i (alarm_minute_i),
    .turn_on_i      (turn_on_i),
    .unix_time_i    (unix_time_i),
    .clock_synced_i (clock_synced_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .resp_kind_o    (resp_kind_o),
    .op_ok_o        (op_ok_o),
    .cmd_relay_o    (cmd_relay_o),
    .cmd_on_o       (cmd_on_o),
    .fired_slot_id_o(fired_slot_id_o),
    .last_o         (last_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Counts and prints the first few failures.
  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Splits Unix time into hour, minute of hour and weekday.
  task automatic decode_wall_time(input logic [31:0] t, output logic [4:0] hour_now,
                                  output logic [5:0] minute_now, output logic [2:0] day_now);
    int unsigned secs;
    secs       = t;
    minute_now = 6'((secs % 3600) / 60);
    hour_now   = 5'((secs % 86400) / 3600);
    day_now    = 3'(((secs / 86400) + 4) % 7);
  endtask

  function automatic alarm_req_t make_req(input logic [1:0] req, input logic [7:0] slot_id,
                                          input logic [7:0] relay, input logic [3:0] weekday,
                                          input logic [4:0] hour, input logic [5:0] minute,
                                          input logic turn_on, input logic [31:0] unix_time,
                                          input logic synced);
    alarm_req_t r;
    r = '{req, slot_id, relay, weekday, hour, minute, turn_on, unix_time, synced};
    return r;
  endfunction

  // Updates the predicted table for one accepted item and queues its results.
  task automatic predict_alarm_results(input alarm_req_t r);
    alarm_result_t res;
    alarm_result_t tail;
    logic [4:0]    hour_now;
    logic [5:0]    minute_now;
    logic [2:0]    day_now;
    bit            id_ok;
    bit            time_hit;
    bit            day_hit;
    int            idx;
    int            i;
    int            emitted;
    id_ok   = (r.slot_id >= 8'd1) && (r.slot_id <= SLOTS);
    idx     = id_ok ? int'(r.slot_id) - 1 : 0;
    res     = '0;
    res.kind    = RESP_ACK;
    res.is_last = 1'b1;
    emitted = 0;
    case (r.req)
      REQ_ADD: begin
        if (id_ok) begin
          table_rule[idx].relay   = r.relay;
          table_rule[idx].weekday = (r.weekday > LAST_DAY) ? WILD_DAY : r.weekday;
          table_rule[idx].hour    = r.hour;
          table_rule[idx].minute  = r.minute;
          table_rule[idx].turn_on = r.turn_on;
          table_live[idx]  = 1'b1;
          table_fired[idx] = 1'b0;
        end
        res.ok = id_ok;
        expected_results.push_back(res);
      end
      REQ_REMOVE: begin
        res.ok = id_ok && table_live[idx];
        if (res.ok) begin
          table_live[idx] = 1'b0;
        end
        expected_results.push_back(res);
      end
      REQ_TICK: begin
        if (r.synced) begin
          decode_wall_time(r.unix_time, hour_now, minute_now, day_now);
          // Only a new minute of the hour triggers a scan.
          if ({1'b0, minute_now} != minute_checked) begin
            minute_checked = {1'b0, minute_now};
            for (i = 0; i < SLOTS; i++) begin
              if (table_live[i]) begin
                time_hit = (table_rule[i].hour == hour_now) &&
                           (table_rule[i].minute == minute_now);
                day_hit  = (table_rule[i].weekday == WILD_DAY) ||
                           (table_rule[i].weekday == {1'b0, day_now});
                if (!time_hit) begin
                  table_fired[i] = 1'b0;
                end
                if (time_hit && day_hit && !table_fired[i]) begin
                  table_fired[i] = 1'b1;
                  if (emitted < MAX_RESULTS) begin
                    res         = '0;
                    res.kind    = RESP_CMD;
                    res.relay   = table_rule[i].relay;
                    res.turn_on = table_rule[i].turn_on;
                    res.slot_id = 5'(i + 1);
                    expected_results.push_back(res);
                    emitted++;
                  end
                end
              end
            end
            // The final command of the scan carries the last flag.
            if (emitted > 0) begin
              tail         = expected_results.pop_back();
              tail.is_last = 1'b1;
              expected_results.push_back(tail);
            end
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  // Offers one item, with an occasional random gap first, and waits until it is taken.
  task automatic send_request(input alarm_req_t r);
    int gap;
    if (!quiet && ($urandom_range(0, 99) < 21)) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 110) : $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= r.req;
    slot_id_i      <= r.slot_id;
    relay_index_i  <= r.relay;
    weekday_code_i <= r.weekday;
    alarm_hour_i   <= r.hour;
    alarm_minute_i <= r.minute;
    turn_on_i      <= r.turn_on;
    unix_time_i    <= r.unix_time;
    clock_synced_i <= r.synced;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_alarm_results(r);
    items_accepted++;
  endtask

  // Drops valid and waits until every predicted result has arrived.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Builds one random item; most are well formed and aimed near the running clock.
  task automatic make_random_request(output alarm_req_t r);
    int          pick;
    logic [31:0] target;
    logic [4:0]  h;
    logic [5:0]  m;
    logic [2:0]  d;
    r.req       = 2'($urandom_range(0, 3));
    r.slot_id   = 8'($urandom_range(0, 255));
    r.relay     = 8'($urandom_range(0, 255));
    r.weekday   = 4'($urandom_range(0, 15));
    r.hour      = 5'($urandom_range(0, 31));
    r.minute    = 6'($urandom_range(0, 63));
    r.turn_on   = 1'($urandom_range(0, 1));
    r.unix_time = $urandom;
    r.synced    = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      r.req = REQ_UNUSED;
    end else if (pick < 35) begin
      r.req = REQ_ADD;
      if ($urandom_range(0, 9) != 0) begin
        r.slot_id = 8'($urandom_range(1, SLOTS));
      end
      // Aim most rules a few minutes ahead so that later ticks hit them.
      if ($urandom_range(0, 9) != 0) begin
        target = wall_clock + $urandom_range(0, 400);
        decode_wall_time(target, h, m, d);
        r.hour   = h;
        r.minute = m;
        case ($urandom_range(0, 4))
          0, 1: r.weekday = 4'($urandom_range(7, 15));
          2, 3: r.weekday = {1'b0, d};
          default: begin
          end
        endcase
      end
    end else if (pick < 47) begin
      r.req = REQ_REMOVE;
      if ($urandom_range(0, 7) != 0) begin
        r.slot_id = 8'($urandom_range(1, SLOTS));
      end
    end else begin
      r.req    = REQ_TICK;
      r.synced = ($urandom_range(0, 9) != 0);
      if (r.synced) begin
        if ($urandom_range(0, 19) == 0) begin
          wall_clock = $urandom;
        end else begin
          wall_clock = wall_clock + $urandom_range(1, 100);
        end
        r.unix_time = wall_clock;
      end
    end
  endtask

  // Sends random items until the given number of them did real work.
  task automatic run_random_items(input int count);
    alarm_req_t r;
    int         done;
    done = 0;
    while (done < count) begin
      make_random_request(r);
      send_request(r);
      if (r.req != REQ_UNUSED && !(r.req == REQ_TICK && !r.synced)) begin
        done++;
      end
    end
    wait_drain();
  endtask

  // Add and remove edge cases: ids out of range, inactive slots, the unused request code.
  task automatic test_table_requests();
    send_request(make_req(REQ_ADD, 8'd0, 8'd1, 4'd0, 5'd0, 6'd0, 1'b1, '0, 1'b0));
    send_request(make_req(REQ_ADD, 8'(SLOTS + 1), 8'd2, 4'd1, 5'd1, 6'd1, 1'b0, '0, 1'b0));
    send_request(make_req(REQ_ADD, 8'd255, 8'd255, 4'd15, 5'd31, 6'd63, 1'b1, '1, 1'b1));
    send_request(make_req(REQ_REMOVE, 8'd5, 8'd0, 4'd0, 5'd0, 6'd0, 1'b0, '0, 1'b0));
    send_request(make_req(REQ_REMOVE, 8'd0, 8'd0, 4'd0, 5'd0, 6'd0, 1'b0, '0, 1'b0));
    send_request(make_req(REQ_REMOVE, 8'd255, 8'd0, 4'd0, 5'd0, 6'd0, 1'b0, '0, 1'b0));
    send_request(make_req(REQ_UNUSED, 8'd3, 8'd9, 4'd3, 5'd3, 6'd3, 1'b1, '1, 1'b1));
    send_request(make_req(REQ_ADD, 8'(SLOTS), 8'hA5, 4'd15, 5'd31, 6'd63, 1'b0, '0, 1'b0));
    send_request(make_req(REQ_REMOVE, 8'(SLOTS), 8'd0, 4'd0, 5'd0, 6'd0, 1'b0, '0, 1'b0));
    send_request(make_req(REQ_REMOVE, 8'(SLOTS), 8'd0, 4'd0, 5'd0, 6'd0, 1'b0, '0, 1'b0));
    wait_drain();
  endtask

  // Tick behavior: sync flag, weekday and wildcard matching, repeated minutes, overwrite.
  task automatic test_tick_matching();
    logic [4:0] h;
    logic [5:0] m;
    logic [2:0] d;
    logic [4:0] h2;
    logic [5:0] m2;
    logic [2:0] d2;
    decode_wall_time(BASE_TIME, h, m, d);
    decode_wall_time(BASE_TIME + 32'd120, h2, m2, d2);
    send_request(make_req(REQ_TICK, 8'd0, 8'd0, 4'd0, 5'd0, 6'd0, 1'b0, BASE_TIME, 1'b0));
    send_request(make_req(REQ_ADD, 8'd1, 8'd255, 4'd7, h, m, 1'b1, '0, 1'b0));
    send_request(make_req(REQ_ADD, 8'd2, 8'd0, {1'b0, d}, h, m, 1'b0, '0, 1'b0));
    send_request(make_req(REQ_ADD, 8'd3, 8'h5A, 4'((int'(d) + 1) % 7), h, m, 1'b1, '0,
                          1'b0));
    send_request(make_req(REQ_ADD, 8'd4, 8'h11, 4'd8, h, 6'd60, 1'b1, '0, 1'b0));
    send_request(make_req(REQ_ADD, 8'd5, 8'h22, 4'd8, 5'd24, m, 1'b1, '0, 1'b0));
    send_request(make_req(REQ_TICK, 8'd0, 8'd0, 4'd0, 5'd0, 6'd0, 1'b0, BASE_TIME, 1'b1));
    // Same minute again, then a new minute with nothing due.
    send_request(make_req(REQ_TICK, 8'd0, 8'd0, 4'd0, 5'd0, 6'd0, 1'b0, BASE_TIME + 32'd30,
                          1'b1));
    send_request(make_req(REQ_TICK, 8'd0, 8'd0, 4'd0, 5'd0, 6'd0, 1'b0, BASE_TIME + 32'd60,
                          1'b1));
    send_request(make_req(REQ_ADD, 8'd1, 8'h3C, 4'd12, h2, m2, 1'b0, '0, 1'b0));
    send_request(make_req(REQ_TICK, 8'd0, 8'd0, 4'd0, 5'd0, 6'd0, 1'b0, BASE_TIME + 32'd120,
                          1'b1));
    // An hour later the minute of the hour is unchanged, so nothing is checked.
    send_request(make_req(REQ_TICK, 8'd0, 8'd0, 4'd0, 5'd0, 6'd0, 1'b0,
                          BASE_TIME + 32'd3720, 1'b1));
    send_request(make_req(REQ_TICK, 8'd0, 8'd0, 4'd0, 5'd0, 6'd0, 1'b0, '0, 1'b1));
    send_request(make_req(REQ_TICK, 8'd0, 8'd0, 4'd0, 5'd0, 6'd0, 1'b0, '1, 1'b1));
    wait_drain();
  endtask

  // Every slot fires on one tick while the receiver holds off, so the block backs up.
  task automatic test_full_table_hold();
    logic [31:0] target;
    logic [4:0]  h;
    logic [5:0]  m;
    logic [2:0]  d;
    alarm_req_t  r;
    int          i;
    target = wall_clock + 32'd60;
    decode_wall_time(target, h, m, d);
    if ({1'b0, m} == minute_checked) begin
      target = target + 32'd60;
      decode_wall_time(target, h, m, d);
    end
    for (i = 1; i <= SLOTS; i++) begin
      send_request(make_req(REQ_ADD, 8'(i), 8'($urandom_range(0, 255)),
                            4'($urandom_range(7, 15)), h, m, 1'($urandom_range(0, 1)),
                            $urandom, 1'($urandom_range(0, 1))));
    end
    hold_req_count <= hold_req_count + 1;
    send_request(make_req(REQ_TICK, 8'd0, 8'd0, 4'd0, 5'd0, 6'd0, 1'b0, target, 1'b1));
    wall_clock = target;
    // Keep offering items while the output is held.
    for (i = 0; i < 6; i++) begin
      make_random_request(r);
      send_request(r);
    end
    wait_drain();
  endtask

  // A stretch of random traffic with neither side idling.
  task automatic test_no_idle_stretch();
    quiet <= 1'b1;
    @(posedge clk_i);
    run_random_items(40);
    quiet <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: random stalls, quiet stretches and one long counted hold-off.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_seen != hold_req_count) begin
      hold_seen   <= hold_req_count;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < 21);
    end
  end

  // Compares each accepted result with the oldest prediction.
  always @(posedge clk_i) begin : result_checker
    alarm_result_t got;
    alarm_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {resp_kind_o, op_ok_o, cmd_relay_o, cmd_on_o, fired_slot_id_o, last_o};
      results_checked++;
      if (got.kind == RESP_CMD) begin
        commands_checked++;
      end
      if (expected_results.size() == 0) begin
        note_failure($sformatf({"cycle %0d: unexpected result kind %0d ok %0d relay %0d ",
                                "on %0d id %0d last %0d"},
                               cycle_count, got.kind, got.ok, got.relay, got.turn_on,
                               got.slot_id, got.is_last));
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind || got.ok !== want.ok || got.relay !== want.relay ||
            got.turn_on !== want.turn_on || got.slot_id !== want.slot_id ||
            got.is_last !== want.is_last) begin
          note_failure($sformatf({"cycle %0d: mismatch, expected kind %0d ok %0d relay %0d ",
                                  "on %0d id %0d last %0d, got kind %0d ok %0d relay %0d ",
                                  "on %0d id %0d last %0d"},
                                 cycle_count, want.kind, want.ok, want.relay, want.turn_on,
                                 want.slot_id, want.is_last, got.kind, got.ok, got.relay,
                                 got.turn_on, got.slot_id, got.is_last));
        end
      end
    end
  end

  // Cycle counter that ends a hung run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_weekly_relay_alarm_table: done, errors");
    $finish;
  end

  // Test sequence.
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_table_requests();
    test_tick_matching();
    wall_clock = $urandom;
    run_random_items(125);
    test_full_table_hold();
    test_no_idle_stretch();

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      note_failure($sformatf("%0d predicted results never arrived", expected_results.size()));
    end

    $display("Run covered %0d accepted items and %0d checked results, %0d relay commands.",
             items_accepted, results_checked, commands_checked);
    $display({"It took in table edge cases, minute filtering, a full-table firing under ",
              "a long output hold-off and an idle-free stretch; %0d failures."},
             fail_count);
    if (fail_count == 0) begin
      $display("tb_weekly_relay_alarm_table: done, clean");
    end else begin
      $display("tb_weekly_relay_alarm_table: done, errors");
    end
    $finish;
  end

endmodule
